// File: rtl/binary_to_decimal_ascii_top_macros.svh
// assertion macros shared by the conversion block
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b2da_pkg.sv
package b2da_pkg;

  // input value width and digit limit
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;

  // decimal digit buffer: enough for any 64-bit value
  localparam int DIGIT_BUF = 20;
  localparam int DIG_IDX_W = $clog2(DIGIT_BUF);
  localparam int BCD_W     = 4 * DIGIT_BUF;

  // shift-and-add-3 conversion, several bits per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int STEP_W        = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int SHIFT_W       = NUM_STEPS * BITS_PER_STEP;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // one classified request
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_zero;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/b2da_front.sv
module b2da_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_value,
  output logic                            push_valid,
  input  logic                            push_ready,
  output b2da_pkg::item_t                 push_item
);

  logic            valid_r;
  b2da_pkg::item_t item_r;
  logic            accept;
  logic [b2da_pkg::VALUE_WIDTH-1:0] masked;

  // take a new request whenever the holding register empties this cycle
  assign in_ready = !valid_r || push_ready;
  assign accept   = in_valid && in_ready;
  assign masked   = in_value[b2da_pkg::VALUE_WIDTH-1:0];

  // holding register with zero classification
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.value   <= masked;
      item_r.is_zero <= (masked == '0);
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// File: rtl/b2da_queue.sv
module b2da_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  b2da_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output b2da_pkg::item_t out_item
);

  b2da_pkg::item_t                 mem_r [b2da_pkg::QUEUE_DEPTH];
  logic [b2da_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [b2da_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [b2da_pkg::QCNT_W-1:0]     cnt_r;
  logic                            push;
  logic                            pop;

  assign in_ready  = (cnt_r != b2da_pkg::QCNT_W'(b2da_pkg::QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// File: rtl/b2da_back.sv
`include "binary_to_decimal_ascii_top_macros.svh"

module b2da_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  b2da_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_digit_char,
  output logic            out_last_digit
);

  b2da_pkg::state_t                 state_r, state_nxt;
  logic [b2da_pkg::SHIFT_W-1:0]     sh_r, sh_nxt;
  logic [b2da_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [b2da_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [b2da_pkg::DIG_IDX_W-1:0]   idx_r, idx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [5:0]                       out_digit_char_r, out_digit_char_nxt;
  logic                             out_last_digit_r, out_last_digit_nxt;
  logic [b2da_pkg::DIG_IDX_W-1:0]   hi_idx;
  logic [3:0]                       cur_digit;
  logic                             emit_load;
  logic                             conv_last;
  logic                             last_load;
  logic                             digit_ok;

  // several shift-and-add-3 steps, msb of the chunk first
  function automatic logic [b2da_pkg::BCD_W-1:0] dabble(
    input logic [b2da_pkg::BCD_W-1:0]         bcd_in,
    input logic [b2da_pkg::BITS_PER_STEP-1:0] bits
  );
    logic [b2da_pkg::BCD_W-1:0] b;
    b = bcd_in;
    for (int k = b2da_pkg::BITS_PER_STEP - 1; k >= 0; k--) begin
      for (int d = 0; d < b2da_pkg::DIGIT_BUF; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[b2da_pkg::BCD_W-2:0], bits[k]};
    end
    return b;
  endfunction

  // most significant nonzero digit, held to the digit limit
  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < b2da_pkg::DIGIT_BUF; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        hi_idx = b2da_pkg::DIG_IDX_W'(i);
      end
    end
    if (hi_idx > b2da_pkg::DIG_IDX_W'(b2da_pkg::MAX_DIGITS - 1)) begin
      hi_idx = b2da_pkg::DIG_IDX_W'(b2da_pkg::MAX_DIGITS - 1);
    end
  end

  assign cur_digit = bcd_r[idx_r*4 +: 4];
  assign emit_load = (state_r == b2da_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign q_ready   = (state_r == b2da_pkg::ST_IDLE);
  assign conv_last = (state_r == b2da_pkg::ST_CONV) &&
                     (step_r == b2da_pkg::STEP_W'(b2da_pkg::NUM_STEPS - 1));
  assign last_load = emit_load && (idx_r == '0);
  assign digit_ok  = (cur_digit <= 4'd9) &&
                     (idx_r <= b2da_pkg::DIG_IDX_W'(b2da_pkg::MAX_DIGITS - 1));

  // sequencer: load, convert (skipped for a zero value), size, emit
  always_comb begin
    state_nxt          = state_r;
    sh_nxt             = sh_r;
    bcd_nxt            = bcd_r;
    step_nxt           = step_r;
    idx_nxt            = idx_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_digit_char_nxt = out_digit_char_r;
    out_last_digit_nxt = out_last_digit_r;
    unique case (state_r)
      b2da_pkg::ST_IDLE: begin
        if (q_valid) begin
          sh_nxt    = b2da_pkg::SHIFT_W'(q_item.value);
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = q_item.is_zero ? b2da_pkg::ST_LEN : b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        bcd_nxt  = dabble(bcd_r, sh_r[b2da_pkg::SHIFT_W-1 -: b2da_pkg::BITS_PER_STEP]);
        sh_nxt   = sh_r << b2da_pkg::BITS_PER_STEP;
        step_nxt = step_r + 1'b1;
        if (conv_last) begin
          state_nxt = b2da_pkg::ST_LEN;
        end
      end
      b2da_pkg::ST_LEN: begin
        idx_nxt   = hi_idx;
        state_nxt = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt      = 1'b1;
          out_digit_char_nxt = b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
          out_last_digit_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = b2da_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2da_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sh_r             <= sh_nxt;
    bcd_r            <= bcd_nxt;
    step_r           <= step_nxt;
    idx_r            <= idx_nxt;
    out_digit_char_r <= out_digit_char_nxt;
    out_last_digit_r <= out_last_digit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_char_r;
  assign out_last_digit = out_last_digit_r;

  // checks
  `B2DA_ASSERT_NEXT(a_conv_ends, conv_last, state_r == b2da_pkg::ST_LEN, "conversion overran")
  `B2DA_ASSERT_NOW(a_emit_digit, state_r == b2da_pkg::ST_EMIT, digit_ok, "digit out of range")
  `B2DA_ASSERT_NEXT(a_last_ends, last_load, out_valid_r && out_last_digit_r && q_ready, "open value")

endmodule

// File: rtl/binary_to_decimal_ascii_top.sv
// path from request to the first digit: front register, queue, load, 16 conversion
// steps of 4 bits each, the sizing state, output register; a zero value skips conversion
// each value gives 1 to 20 digits; the back-end shift-and-add-3 sequencer takes a new
// value only after the last digit of the previous one; front and queue buffer requests
// reset: synchronous active-low rst_n clears valid flags, queue pointers and the sequencer
module binary_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_digit_char,
  output logic        out_last_digit
);

  logic            push_valid;
  logic            push_ready;
  b2da_pkg::item_t push_item;
  logic            q_valid;
  logic            q_ready;
  b2da_pkg::item_t q_item;

  // request intake and classification
  b2da_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // short queue decoupling the two halves
  b2da_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // conversion and digit output
  b2da_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
